// ----- src/hfi_pkg.sv -----
// ----------------------------------------------------------------------------
// hfi_pkg
// Shared constants, coefficient tables and item types for the interpolator.
// ----------------------------------------------------------------------------
`default_nettype none
package hfi_pkg;
  localparam int MAX_SIDE   = 64;
  localparam int STORE_ROWS = 7;
  localparam int COL_W      = $clog2(MAX_SIDE + 8);
  localparam int CIDX_W     = $clog2(MAX_SIDE);
  localparam int SLOT_W     = 3;
  localparam int ADDR_W     = $clog2(STORE_ROWS * MAX_SIDE);
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_FRACX  = 3'd2;
  localparam logic [2:0] REG_FRACY  = 3'd3;
  localparam logic [2:0] REG_CHROMA = 3'd4;

  // classified job handed from the front to the back
  typedef struct packed {
    logic signed [16:0] hv;        // horizontal result (fits 17 bits signed)
    logic               vpass;     // vertical filter needed
    logic               emit;      // produce an output item
    logic               shift6;    // floor shift by 6 after vertical
    logic               fullpel;   // multiply by 64
    logic [SLOT_W-1:0]  wslot;     // row slot to write
    logic [SLOT_W-1:0]  rslot0;    // first slot of vertical taps
    logic [CIDX_W-1:0]  col;
    logic               last;
  } job_t;

  typedef struct packed {
    logic [6:0] w;
    logic [6:0] h;
    logic [2:0] fx;
    logic [2:0] fy;
    logic       chroma;
  } cfg_t;

  function automatic logic signed [7:0] coef(input logic chroma, input logic [2:0] ph,
                                             input logic [2:0] k);
    logic signed [7:0] c;
    c = 8'sd0;
    if (chroma) begin
      unique case ({ph, k[1:0]})
        5'b00000: c = 8'sd0;   5'b00001: c = 8'sd64;  5'b00010: c = 8'sd0;   5'b00011: c = 8'sd0;
        5'b00100: c = -8'sd2;  5'b00101: c = 8'sd58;  5'b00110: c = 8'sd10;  5'b00111: c = -8'sd2;
        5'b01000: c = -8'sd4;  5'b01001: c = 8'sd54;  5'b01010: c = 8'sd16;  5'b01011: c = -8'sd2;
        5'b01100: c = -8'sd6;  5'b01101: c = 8'sd46;  5'b01110: c = 8'sd28;  5'b01111: c = -8'sd4;
        5'b10000: c = -8'sd4;  5'b10001: c = 8'sd36;  5'b10010: c = 8'sd36;  5'b10011: c = -8'sd4;
        5'b10100: c = -8'sd4;  5'b10101: c = 8'sd28;  5'b10110: c = 8'sd46;  5'b10111: c = -8'sd6;
        5'b11000: c = -8'sd2;  5'b11001: c = 8'sd16;  5'b11010: c = 8'sd54;  5'b11011: c = -8'sd4;
        default:  c = (k[1:0] == 2'd0 || k[1:0] == 2'd3) ? -8'sd2 :
                      (k[1:0] == 2'd1) ? 8'sd10 : 8'sd58;
      endcase
    end else begin
      unique case ({ph[1:0], k})
        5'b00011: c = 8'sd64;
        5'b01000: c = -8'sd1; 5'b01001: c = 8'sd4;  5'b01010: c = -8'sd10; 5'b01011: c = 8'sd58;
        5'b01100: c = 8'sd17; 5'b01101: c = -8'sd5; 5'b01110: c = 8'sd1;
        5'b10000: c = -8'sd1; 5'b10001: c = 8'sd4;  5'b10010: c = -8'sd11; 5'b10011: c = 8'sd40;
        5'b10100: c = 8'sd40; 5'b10101: c = -8'sd11; 5'b10110: c = 8'sd4;  5'b10111: c = -8'sd1;
        5'b11001: c = 8'sd1;  5'b11010: c = -8'sd5; 5'b11011: c = 8'sd17;  5'b11100: c = 8'sd58;
        5'b11101: c = -8'sd10; 5'b11110: c = 8'sd4; 5'b11111: c = -8'sd1;
        default:  c = 8'sd0;
      endcase
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ----- src/hfi_if.sv -----
// ----------------------------------------------------------------------------
// hfi_if
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface hfi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ref_sample;
  modport source (output valid, output ref_sample, input ready);
  modport sink   (input valid, input ref_sample, output ready);
endinterface

interface hfi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pred_value;
  logic               last_of_block;
  modport source (output valid, output pred_value, output last_of_block, input ready);
  modport sink   (input valid, input pred_value, input last_of_block, output ready);
endinterface

interface hfi_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [6:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/hfi_front.sv -----
// ----------------------------------------------------------------------------
// hfi_front
// Window tracking and horizontal filtering; classifies each result into a job.
// ----------------------------------------------------------------------------
`default_nettype none
module hfi_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hfi_pkg::cfg_t cfg,
  input  wire logic          restart,
  input  wire logic          take,
  input  wire logic [7:0]    sample,
  output hfi_pkg::job_t      job,
  output logic               job_valid
);
  import hfi_pkg::*;

  logic [7:0]       tap_r [8];
  logic [COL_W-1:0] wc_r, wr_r, wc_nxt, wr_nxt;
  logic [SLOT_W-1:0] wslot_r, wslot_nxt, vbase_r, vbase_nxt;
  logic [6:0]       w, h;
  logic [2:0]       fx, fy, pre, span;
  logic [7:0]       t [8];
  logic signed [16:0] acc;
  logic             have_h, emit;
  logic [COL_W-1:0] c, r;

  always_comb begin
    w = (cfg.w == 7'd0) ? 7'd1 : (cfg.w > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : cfg.w;
    h = (cfg.h == 7'd0) ? 7'd1 : (cfg.h > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : cfg.h;
    pre  = cfg.chroma ? 3'd1 : 3'd3;
    span = cfg.chroma ? 3'd3 : 3'd7;
    fx = cfg.chroma ? cfg.fx : {1'b0, cfg.fx[1:0]};
    fy = cfg.chroma ? cfg.fy : {1'b0, cfg.fy[1:0]};
    for (int i = 0; i < 7; i++) t[i] = tap_r[i+1];
    t[7] = sample;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (cfg.chroma) begin
        if (k >= 4) acc = acc + 17'(coef(1'b1, fx, 3'(k-4)) * $signed({1'b0, t[k]}));
      end else begin
        acc = acc + 17'(coef(1'b0, fx, 3'(k)) * $signed({1'b0, t[k]}));
      end
    end
    have_h = 1'b0;
    c = '0;
    if (fx == 3'd0) begin
      if (wc_r >= COL_W'(pre) && wc_r - COL_W'(pre) < COL_W'(w)) begin
        c = wc_r - COL_W'(pre); have_h = 1'b1;
        acc = 17'($signed({1'b0, sample}));
      end
    end else if (wc_r >= COL_W'(span) && wc_r - COL_W'(span) < COL_W'(w)) begin
      c = wc_r - COL_W'(span); have_h = 1'b1;
    end
    emit = 1'b0;
    r = '0;
    if (fy == 3'd0) begin
      if (wr_r >= COL_W'(pre) && wr_r - COL_W'(pre) < COL_W'(h)) begin
        r = wr_r - COL_W'(pre); emit = have_h;
      end
    end else if (wr_r >= COL_W'(span) && wr_r - COL_W'(span) < COL_W'(h)) begin
      r = wr_r - COL_W'(span); emit = have_h;
    end
    job.hv      = acc;
    job.vpass   = (fy != 3'd0);
    job.emit    = emit;
    job.shift6  = (fx != 3'd0);
    job.fullpel = (fx == 3'd0);
    job.wslot   = wslot_r;
    job.rslot0  = vbase_r;
    job.col     = c[CIDX_W-1:0];
    job.last    = (r == COL_W'(h) - 1'b1) && (c == COL_W'(w) - 1'b1);
    job_valid   = take && have_h;

    wc_nxt = wc_r + 1'b1; wr_nxt = wr_r;
    wslot_nxt = wslot_r; vbase_nxt = vbase_r;
    if (wc_nxt >= COL_W'(w) + COL_W'(span)) begin
      wc_nxt = '0; wr_nxt = wr_r + 1'b1;
      // slot written is wr % span; vertical base is (wr-span) % span == wr % span
      wslot_nxt = (wslot_r == span - 3'd1) ? 3'd0 : wslot_r + 3'd1;
      if (wr_r >= COL_W'(span)) vbase_nxt = (vbase_r == span - 3'd1) ? 3'd0 : vbase_r + 3'd1;
      if (wr_nxt >= COL_W'(h) + COL_W'(span)) begin
        wr_nxt = '0; wslot_nxt = '0; vbase_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r <= '0; wr_r <= '0; wslot_r <= '0; vbase_r <= '0;
      for (int i = 0; i < 8; i++) tap_r[i] <= '0;
    end else if (restart) begin
      wc_r <= '0; wr_r <= '0; wslot_r <= '0; vbase_r <= '0;
    end else if (take) begin
      wc_r <= wc_nxt; wr_r <= wr_nxt; wslot_r <= wslot_nxt; vbase_r <= vbase_nxt;
      for (int i = 0; i < 8; i++) tap_r[i] <= t[i];
    end
  end
endmodule
`default_nettype wire

// ----- src/hfi_queue.sv -----
// ----------------------------------------------------------------------------
// hfi_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none
module hfi_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire hfi_pkg::job_t din,
  input  wire logic          pop,
  output hfi_pkg::job_t      dout,
  output logic               nonempty,
  output logic               space2
);
  import hfi_pkg::*;
  job_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0] cnt_r;

  assign dout = mem_r[rp_r];
  assign nonempty = (cnt_r != '0);
  assign space2 = (cnt_r <= (QPTR_W+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end
endmodule
`default_nettype wire

// ----- src/hfi_back.sv -----
// ----------------------------------------------------------------------------
// hfi_back
// Vertical pass: one row-store tap per cycle through a shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none
module hfi_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hfi_pkg::cfg_t cfg,
  input  wire hfi_pkg::job_t job,
  input  wire logic          job_valid,
  output logic               job_pop,
  output logic               busy,
  hfi_out_if.source          out
);
  import hfi_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_READ = 4'b0010, S_ACC = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic signed [15:0] store [STORE_ROWS * MAX_SIDE];
  job_t               job_r;
  logic [2:0]         k_r, span;
  logic [SLOT_W-1:0]  slot_r;
  logic signed [15:0] rd_r;
  logic signed [23:0] prod_r;
  logic               prod_v_r;
  logic signed [25:0] sum_r;
  logic signed [15:0] res_r;
  logic               last_r;
  logic [2:0]         fy;
  logic signed [25:0] fin;
  logic signed [16:0] hv16;

  assign span = cfg.chroma ? 3'd3 : 3'd7;
  assign fy = cfg.chroma ? cfg.fy : {1'b0, cfg.fy[1:0]};
  assign busy = (state_r != S_IDLE) || out.valid;
  assign out.pred_value = res_r;
  assign out.last_of_block = last_r;
  // take the next job once the output register is free or drains this cycle
  assign job_pop = (state_r == S_IDLE) && job_valid && (!out.valid || out.ready);
  assign hv16 = job_r.hv;

  function automatic logic [ADDR_W-1:0] addr(input logic [SLOT_W-1:0] s,
                                             input logic [CIDX_W-1:0] c);
    return ADDR_W'(s) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
  endfunction

  always_comb begin
    fin = sum_r + 26'(prod_r);
    if (job_r.vpass && job_r.shift6) fin = fin >>> 6;
    else if (!job_r.vpass && job_r.fullpel) fin = 26'(hv16) <<< 6;
    else if (!job_r.vpass) fin = 26'(hv16);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (job_pop) state_nxt = S_READ;
      S_READ: state_nxt = (!job_r.vpass) ? (job_r.emit ? S_OUT : S_IDLE) : S_ACC;
      S_ACC:  if (k_r == span && prod_v_r) state_nxt = job_r.emit ? S_OUT : S_IDLE;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out.valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out.valid && out.ready) out.valid <= 1'b0;
      if (state_r == S_OUT) out.valid <= 1'b1;
    end
  end

  // datapath: taps k = 0..span-1 read from the store, tap span is hv
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (job_pop) job_r <= job;
        k_r <= '0; prod_v_r <= 1'b0; sum_r <= '0; prod_r <= '0;
      end
      S_READ: begin
        slot_r <= job_r.rslot0;
        rd_r <= store[addr(job_r.rslot0, job_r.col)];
        if (!job_r.vpass) begin
          res_r <= (fin > 26'sd32767) ? 16'sh7fff : (fin < -26'sd32768) ? -16'sh8000 : 16'(fin);
          last_r <= job_r.last;
        end
      end
      S_ACC: begin
        if (prod_v_r) sum_r <= sum_r + 26'(prod_r);
        if (k_r < span) begin
          prod_r <= 24'(coef(cfg.chroma, fy, k_r) * rd_r);
          slot_r <= (slot_r == span - 3'd1) ? 3'd0 : slot_r + 3'd1;
          rd_r <= store[addr((slot_r == span - 3'd1) ? 3'd0 : slot_r + 3'd1, job_r.col)];
          prod_v_r <= 1'b1;
          k_r <= k_r + 3'd1;
        end else if (!prod_v_r) begin
          prod_r <= '0;
        end else begin
          prod_r <= 24'(coef(cfg.chroma, fy, span) * hv16);
          prod_v_r <= 1'b0;
        end
        if (k_r == span && prod_v_r) begin
          store[addr(job_r.wslot, job_r.col)] <= 16'(job_r.hv);
        end
      end
      S_OUT: begin
        if (job_r.vpass) begin
          res_r <= (fin > 26'sd32767) ? 16'sh7fff : (fin < -26'sd32768) ? -16'sh8000 : 16'(fin);
          last_r <= job_r.last;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- src/hevc_fractional_interpolation.sv -----
// ----------------------------------------------------------------------------
// hevc_fractional_interpolation
// H.265 luma/chroma sub-pel interpolation to 16-bit signed intermediates.
// ----------------------------------------------------------------------------
// Usage: stream the (w+T-1) x (h+T-1) reference window on in_, one 8-bit
// sample per item in raster order; read prediction samples on out_, in
// raster order of the block, last_of_block marking the final one.
// Write registers on cfg_ only while idle; cfg_ready stays low while jobs are
// in flight, in_ready is low during a write, writes to 0-4 restart the window.
// Front: window counters, tap line and horizontal filter, one item a cycle
// while in_ready is high. Queue: four jobs decouple it from the vertical
// back end; in_ready falls once three jobs wait.
// Back: one shared multiplier walks the row-store taps, one tap per cycle
// from a single-port row store; a vertical job steps through S_IDLE,
// S_READ, S_ACC and S_OUT (no S_OUT when it only updates the row store),
// a non-vertical job through S_IDLE, S_READ and S_OUT (no S_OUT without
// a result); a new job is taken only in S_IDLE. Samples with no horizontal
// result make no job. With an empty queue out_valid rises as S_OUT ends.
// Reset clears counters, taps and the queue; the row store holds garbage
// until the first rows of a window have written it.
// A stalled receiver holds the output register; the queue then fills and
// in_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none
module hevc_fractional_interpolation (
  input  wire logic clk,
  input  wire logic rst_n,
  hfi_in_if.sink    in,
  hfi_out_if.source out,
  hfi_cfg_if.sink   cfg
);
  import hfi_pkg::*;

  cfg_t cfg_r;
  job_t fjob, qjob;
  logic fvalid, take, pop, nonempty, space2, busy;

  // accept a sample only with room for its job; hold samples during a write
  assign in.ready = space2 && !cfg.valid;
  assign take = in.valid && in.ready;
  // accept register writes only with nothing in flight
  assign cfg.ready = !busy && !nonempty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{w: 7'd8, h: 7'd8, fx: 3'd0, fy: 3'd0, chroma: 1'b0};
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_WIDTH:  cfg_r.w <= cfg.data;
        REG_HEIGHT: cfg_r.h <= cfg.data;
        REG_FRACX:  cfg_r.fx <= cfg.data[2:0];
        REG_FRACY:  cfg_r.fy <= cfg.data[2:0];
        REG_CHROMA: cfg_r.chroma <= cfg.data[0];
        default: ;
      endcase
    end
  end

  hfi_front u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .restart(cfg.valid && cfg.ready && cfg.index <= REG_CHROMA),
    .take, .sample(in.ref_sample), .job(fjob), .job_valid(fvalid)
  );

  hfi_queue u_queue (
    .clk, .rst_n, .push(fvalid), .din(fjob), .pop, .dout(qjob),
    .nonempty, .space2
  );

  hfi_back u_back (
    .clk, .rst_n, .cfg(cfg_r), .job(qjob), .job_valid(nonempty),
    .job_pop(pop), .busy, .out
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty) else $error("job popped from empty queue");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid && !out.ready |=> out.valid && $stable(out.pred_value))
    else $error("output dropped while stalled");
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out.valid |-> busy) else $error("busy low with pending result");
endmodule
`default_nettype wire

// ----- tb/hevc_fractional_interpolation_test.sv -----
// ----------------------------------------------------------------------------
// hevc_fractional_interpolation_test
// Streams reference windows into the sub-pel interpolator and checks every
// prediction sample against a cycle-free predictor of the H.265 filters.
// ----------------------------------------------------------------------------
`default_nettype none
module hevc_fractional_interpolation_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hfi_pkg::*;

  localparam int  TARGET_ITEMS = 240;
  localparam int  DRAIN_CYCLES = 60;
  localparam int  CYCLE_LIMIT  = 600000;

  localparam int LUMA_TAB [4][8] = '{
    '{ 0, 0,   0, 64,  0,   0, 0,  0},
    '{-1, 4, -10, 58, 17,  -5, 1,  0},
    '{-1, 4, -11, 40, 40, -11, 4, -1},
    '{ 0, 1,  -5, 17, 58, -10, 4, -1}
  };
  localparam int CHROMA_TAB [8][4] = '{
    '{ 0, 64,  0,  0}, '{-2, 58, 10, -2}, '{-4, 54, 16, -2}, '{-6, 46, 28, -4},
    '{-4, 36, 36, -4}, '{-4, 28, 46, -6}, '{-2, 16, 54, -4}, '{-2, 10, 58, -2}
  };

  typedef struct {
    logic signed [15:0] pred;
    logic               last;
  } pred_sample_t;

  logic clk;
  logic rst_n;

  hfi_in_if  in_ch ();
  hfi_out_if out_ch ();
  hfi_cfg_if cfg_ch ();

  hevc_fractional_interpolation dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in    (in_ch),
    .out   (out_ch),
    .cfg   (cfg_ch)
  );

  // Predictor state: registers, tap line, row store, window position.
  logic [6:0]   blk_w_reg, blk_h_reg;
  logic [2:0]   phase_x_reg, phase_y_reg;
  logic         chroma_reg;
  logic [7:0]   tap_line [8];
  int           row_mem [STORE_ROWS * MAX_SIDE];
  int           win_col, win_row;

  pred_sample_t expected_preds [$];
  int           samples_sent;
  int           mismatches;
  int           cycle_count;
  int           send_idle_pct, recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int filter_coef(logic chroma, int phase, int k);
    if (chroma) return CHROMA_TAB[phase & 7][k & 3];
    return LUMA_TAB[phase & 3][k & 7];
  endfunction

  function automatic int clamp_side(int v);
    if (v < 1) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic int window_items();
    int taps;
    taps = chroma_reg ? 4 : 8;
    return (clamp_side(blk_w_reg) + taps - 1) * (clamp_side(blk_h_reg) + taps - 1);
  endfunction

  // Advance the predictor by one sample; queue the prediction it yields.
  function automatic void interpolate_sample(logic [7:0] s);
    int taps, pre, fx, fy, w, h, c, r, hv, acc, val, span;
    bit have_h, emit;
    pred_sample_t ps;
    taps = chroma_reg ? 4 : 8;
    pre  = taps / 2 - 1;
    fx   = chroma_reg ? phase_x_reg : phase_x_reg[1:0];
    fy   = chroma_reg ? phase_y_reg : phase_y_reg[1:0];
    w    = clamp_side(blk_w_reg);
    h    = clamp_side(blk_h_reg);
    span = taps - 1;
    have_h = 0; emit = 0; c = 0; r = 0; hv = 0; val = 0;
    for (int i = 0; i < 7; i++) tap_line[i] = tap_line[i + 1];
    tap_line[7] = s;

    if (fx == 0) begin
      if (win_col >= pre && win_col - pre < w) begin
        c = win_col - pre; hv = s; have_h = 1;
      end
    end else if (win_col >= span && win_col - span < w) begin
      c = win_col - span;
      for (int k = 0; k < taps; k++)
        hv += filter_coef(chroma_reg, fx, k) * int'(tap_line[8 - taps + k]);
      have_h = 1;
    end

    if (have_h) begin
      if (fy == 0) begin
        if (win_row >= pre && win_row - pre < h) begin
          r = win_row - pre; val = fx ? hv : hv * 64; emit = 1;
        end
      end else begin
        if (win_row >= span && win_row - span < h) begin
          r = win_row - span;
          acc = filter_coef(chroma_reg, fy, span) * hv;
          for (int k = 0; k < span; k++)
            acc += filter_coef(chroma_reg, fy, k) * row_mem[((r + k) % span) * MAX_SIDE + c];
          val = fx ? (acc >>> 6) : acc;   // arithmetic shift floors
          emit = 1;
        end
        row_mem[(win_row % span) * MAX_SIDE + c] = hv;
      end
    end

    win_col++;
    if (win_col >= w + span) begin
      win_col = 0;
      win_row++;
      if (win_row >= h + span) win_row = 0;
    end

    if (emit) begin
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      ps.pred = val[15:0];
      ps.last = (r == h - 1 && c == w - 1);
      expected_preds.push_back(ps);
    end
  endfunction

  // Send one sample; idle the channel at random first.
  task automatic send_sample(logic [7:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.ref_sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    interpolate_sample(s);
    samples_sent++;
  endtask

  task automatic hold_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Drain the block before touching a register: windows end on samples that
  // yield nothing, so hold off for the back-end latency as well.
  task automatic wait_idle();
    hold_input();
    wait (expected_preds.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [6:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_WIDTH:  blk_w_reg   = data;
      REG_HEIGHT: blk_h_reg   = data;
      REG_FRACX:  phase_x_reg = data[2:0];
      REG_FRACY:  phase_y_reg = data[2:0];
      REG_CHROMA: chroma_reg  = data[0];
      default: ;
    endcase
    win_col = 0;
    win_row = 0;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Program all registers; upper bits of phase and mode words are don't-care.
  task automatic program_block(int w, int h, int fx, int fy, bit chroma);
    wait_idle();
    write_reg(REG_WIDTH,  7'(w));
    write_reg(REG_HEIGHT, 7'(h));
    write_reg(REG_FRACX,  {4'($urandom), 3'(fx)});
    write_reg(REG_FRACY,  {4'($urandom), 3'(fy)});
    write_reg(REG_CHROMA, {6'($urandom), chroma});
  endtask

  task automatic send_random_samples(int n);
    for (int i = 0; i < n; i++) send_sample(8'($urandom));
  endtask

  // Full-pel copy at the sample extremes, smallest chroma block.
  task automatic test_fullpel_extremes();
    program_block(1, 1, 0, 0, 1'b1);
    for (int i = 0; i < 16; i++) send_sample((i % 2) ? 8'hFF : 8'h00);
    for (int i = 0; i < 16; i++) send_sample((i == 5) ? 8'hFF : 8'h00);
  endtask

  // Out-of-range sizes clamp; top phases on both axes.
  task automatic test_size_clamp();
    program_block(0, 0, 7, 7, 1'b1);
    send_random_samples(16);
    program_block(127, 1, 3, 5, 1'b1);
    send_random_samples(67 * 4);
  endtask

  // Half-pel luma two-pass with a checkerboard that drives the sum past
  // 16 bits; the result must saturate.
  task automatic test_saturation();
    bit xpos, ypos;
    program_block(1, 1, 2, 2, 1'b0);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) begin
        xpos = LUMA_TAB[2][c] > 0;
        ypos = LUMA_TAB[2][r] > 0;
        send_sample((xpos == ypos) ? 8'hFF : 8'h00);
      end
    // Inverted pattern pushes toward the negative limit.
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++) begin
        xpos = LUMA_TAB[2][c] > 0;
        ypos = LUMA_TAB[2][r] > 0;
        send_sample((xpos != ypos) ? 8'hFF : 8'h00);
      end
  endtask

  // One window for each mode of both axes: full-pel, horizontal, vertical,
  // two-pass, for luma and chroma.
  task automatic test_filter_modes();
    for (int m = 0; m < 8; m++) begin
      program_block(2, 1, (m & 1) ? 1 + (m % 3) : 0, (m & 2) ? 3 : 0, m[2]);
      send_random_samples(window_items());
    end
  endtask

  // Random blocks of random shape and phase; mostly whole windows, some cut
  // short, and each third under a different idle pattern.
  task automatic test_random_blocks();
    int start, w, h, n;
    bit chroma;
    start = samples_sent;
    while (samples_sent - start < TARGET_ITEMS) begin
      if (samples_sent - start < TARGET_ITEMS / 3) begin
        send_idle_pct = 23; recv_stall_pct = 71;
      end else if (samples_sent - start < 2 * TARGET_ITEMS / 3) begin
        send_idle_pct = 71; recv_stall_pct = 23;
      end else begin
        send_idle_pct = 0; recv_stall_pct = 0;
      end
      chroma = $urandom_range(1);
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      if ($urandom_range(19) == 0) begin
        w = $urandom_range(1) ? 64 : 1;
        h = (w == 64) ? 1 : 64;
        chroma = 1'b1;
      end
      program_block(w, h, $urandom_range(7), $urandom_range(7), chroma);
      n = $urandom_range(1, 2);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(9) == 0) send_random_samples($urandom_range(1, window_items() - 1));
        else                        send_random_samples(window_items());
        if ($urandom_range(9) == 0) wait_idle();
      end
    end
  endtask

  // Receiver: stall at random at the falling edge.
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Check each prediction sample against the oldest expectation.
  always @(posedge clk) begin
    pred_sample_t ps;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_preds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: pred %0d last %0b", out_ch.pred_value,
                   out_ch.last_of_block);
      end else begin
        ps = expected_preds.pop_front();
        if (out_ch.pred_value !== ps.pred || out_ch.last_of_block !== ps.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pred exp %0d got %0d, last exp %0b got %0b",
                     ps.pred, out_ch.pred_value, ps.last, out_ch.last_of_block);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.ref_sample = 8'h00;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_WIDTH;
    cfg_ch.data      = 7'd0;
    blk_w_reg = 7'd8; blk_h_reg = 7'd8;
    phase_x_reg = 3'd0; phase_y_reg = 3'd0; chroma_reg = 1'b0;
    for (int i = 0; i < 8; i++) tap_line[i] = 8'h00;
    for (int i = 0; i < STORE_ROWS * MAX_SIDE; i++) row_mem[i] = 0;
    win_col = 0; win_row = 0;
    samples_sent = 0; mismatches = 0; cycle_count = 0;
    send_idle_pct = 23; recv_stall_pct = 71;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_fullpel_extremes();
    test_saturation();
    test_size_clamp();
    test_filter_modes();
    test_random_blocks();

    hold_input();
    wait (expected_preds.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("CHECK OK");
    else                 $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
